// ----- sv/grp_pkg.sv -----
// Package for the guillotine rectangle packer: sizes, entry type, codes.
// No dependencies.
package grp_pkg;
    localparam int FREE_ENTRIES = 64;
    localparam int MAX_PAGES    = 256;
    localparam int DIM_BITS     = 13;
    localparam int IDX_BITS     = $clog2(FREE_ENTRIES);
    localparam int CNT_BITS     = $clog2(FREE_ENTRIES + 1);
    localparam int PG_BITS      = 8;
    localparam int PGC_BITS     = $clog2(MAX_PAGES + 1);
    localparam int AREA_BITS    = 2 * (DIM_BITS + 1);

    localparam logic [1:0] ST_PLACED = 2'd0;
    localparam logic [1:0] ST_TOOBIG = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    localparam logic REG_PAGE_W = 1'b0;
    localparam logic REG_PAGE_H = 1'b1;

    typedef struct packed {
        logic [PG_BITS-1:0]  page;
        logic [DIM_BITS-1:0] x;
        logic [DIM_BITS-1:0] y;
        logic [DIM_BITS-1:0] w;
        logic [DIM_BITS-1:0] h;
    } t_entry;

    // memory access request from the sequencer
    typedef struct packed {
        logic                we;
        logic [IDX_BITS-1:0] waddr;
        t_entry              wdata;
        logic [IDX_BITS-1:0] raddr;
    } t_mem_req;
endpackage

// ----- sv/grp_table.sv -----
// Free-rectangle table: one write port, one registered read port.
// Depends on grp_pkg.
module grp_table (
    input  logic              i_clk,
    input  grp_pkg::t_mem_req i_req,
    output grp_pkg::t_entry   o_rdata
);
    import grp_pkg::*;

    t_entry r_mem [FREE_ENTRIES];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- sv/guillotine_rect_packer.sv -----
// Top level of the guillotine rectangle packer: sequencer, scan and split.
// Depends on grp_pkg and grp_table.
//
//  port group    | dir | tdata / tuser fields (low bit first)
//  s_axis        | in  | rect_width[12:0] rect_height[25:13] pad[33:26], pad to 40
//  m_axis        | out | status[1:0] page_index[9:2] pos_x[22:10] pos_y[35:23], pad to 40
//  cfg write     | in  | index 0 page_width, 1 page_height
//
// Sequence: a placed request scans the table, reading one entry per cycle through
// the single read port, then drains the compare pipeline (fit test, registered area),
// then pick, read-back, split and write-back; a full-table rejection ends after the
// pick, and a too-large request goes straight to the output.
// Reset: synchronous, active low; clears counts and sets page sizes to 1024. The
// table contents are not cleared: only entries below the fill count are read.
// Stalls: the result sits in an output register; the next request is taken
// while it waits, and a new result is held back until the register is free.
module guillotine_rect_packer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // rect_width, rect_height, pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // status, page_index, pos_x, pos_y
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [12:0] i_cfg_wdata
);
    import grp_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_PICK  = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;
    localparam logic [2:0] S_SPLIT = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]          r_state, n_state;
    logic [DIM_BITS-1:0] r_page_w, r_page_h;
    logic [CNT_BITS-1:0] r_count;
    logic [PGC_BITS-1:0] r_pages;
    logic [DIM_BITS:0]   r_aw, r_ah;
    logic [7:0]          r_pad;
    logic [CNT_BITS-1:0] r_rd_idx;      // next address to read
    logic [CNT_BITS-1:0] r_cmp_idx;     // index of the entry in rdata
    logic                r_cmp_vld;
    logic                r_mul_vld;
    logic [IDX_BITS-1:0] r_mul_idx;
    logic [AREA_BITS-1:0] r_mul_area;
    logic                r_found;
    logic [IDX_BITS-1:0] r_best;
    logic [AREA_BITS-1:0] r_best_area;
    logic                r_newpage;
    logic                r_ovld;
    logic [39:0]         r_odata;
    logic [1:0]          r_res_st;
    t_entry              r_ent;

    t_mem_req            w_req;
    t_entry              w_rdata;
    logic                w_fit;
    logic [AREA_BITS-1:0] w_area;

    grp_table u_table (.i_clk(i_clk), .i_req(w_req), .o_rdata(w_rdata));

    wire w_in_xfer  = s_axis_tvalid && s_axis_tready;
    wire w_out_xfer = m_axis_tvalid && m_axis_tready;
    wire [DIM_BITS:0] w_in_aw = {1'b0, s_axis_tdata[12:0]} + {5'd0, s_axis_tdata[33:26], 1'b0};
    wire [DIM_BITS:0] w_in_ah = {1'b0, s_axis_tdata[25:13]} + {5'd0, s_axis_tdata[33:26], 1'b0};
    wire w_in_big = (w_in_aw > {1'b0, r_page_w}) || (w_in_ah > {1'b0, r_page_h});

    // a found entry needs one slot for the split part, a new page needs two
    wire w_pick_full = r_found ? (r_count + 1'b1 > CNT_BITS'(FREE_ENTRIES))
                               : (r_pages >= PGC_BITS'(MAX_PAGES) ||
                                  r_count + 2'd2 > CNT_BITS'(FREE_ENTRIES));

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_odata;

    // fit test on the entry just read; the area multiply is registered
    assign w_fit  = (r_aw <= {1'b0, w_rdata.w}) && (r_ah <= {1'b0, w_rdata.h});
    assign w_area = AREA_BITS'({1'b0, w_rdata.w} * {1'b0, w_rdata.h});

    // split arithmetic (all widths truncate to DIM_BITS as the entries do)
    wire [DIM_BITS-1:0] w_aw = r_aw[DIM_BITS-1:0];
    wire [DIM_BITS-1:0] w_ah = r_ah[DIM_BITS-1:0];
    wire [DIM_BITS:0]   w_lw = {1'b0, r_ent.w} - r_aw;
    wire [DIM_BITS:0]   w_lh = {1'b0, r_ent.h} - r_ah;
    wire                w_horz = w_lw < w_lh;

    always_comb begin
        w_req       = '0;
        w_req.raddr = (r_state == S_PICK) ? r_best : r_rd_idx[IDX_BITS-1:0];
        if (r_state == S_PICK && !r_found && !w_pick_full) begin
            w_req.we    = 1'b1;
            w_req.waddr = r_count[IDX_BITS-1:0];
            w_req.wdata = '{page: r_pages[PG_BITS-1:0], x: '0, y: '0,
                            w: r_page_w, h: r_page_h};
        end else if (r_state == S_SPLIT) begin
            // appended part
            w_req.we    = 1'b1;
            w_req.waddr = r_count[IDX_BITS-1:0];
            w_req.wdata.page = r_ent.page;
            if (w_horz) begin
                w_req.wdata.x = r_ent.x;
                w_req.wdata.y = r_ent.y + w_ah;
                w_req.wdata.w = r_ent.w;
                w_req.wdata.h = w_lh[DIM_BITS-1:0];
            end else begin
                w_req.wdata.x = r_ent.x + w_aw;
                w_req.wdata.y = r_ent.y;
                w_req.wdata.w = w_lw[DIM_BITS-1:0];
                w_req.wdata.h = r_ent.h;
            end
        end else if (r_state == S_OUT && r_res_st == ST_PLACED) begin
            // replacement of the chosen entry
            w_req.we    = 1'b1;
            w_req.waddr = r_best;
            w_req.wdata.page = r_ent.page;
            if (w_horz) begin
                w_req.wdata.x = r_ent.x + w_aw;
                w_req.wdata.y = r_ent.y;
                w_req.wdata.w = w_lw[DIM_BITS-1:0];
                w_req.wdata.h = w_ah;
            end else begin
                w_req.wdata.x = r_ent.x;
                w_req.wdata.y = r_ent.y + w_ah;
                w_req.wdata.w = w_aw;
                w_req.wdata.h = w_lh[DIM_BITS-1:0];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_in_xfer) n_state = w_in_big ? S_OUT : S_SCAN;
            S_SCAN:  if (!r_cmp_vld && !r_mul_vld && r_rd_idx >= r_count) n_state = S_PICK;
            S_MUL:   n_state = S_PICK;
            S_PICK:  n_state = w_pick_full ? S_OUT : S_READ;
            S_READ:  n_state = S_SPLIT;
            S_SPLIT: n_state = S_OUT;
            S_OUT:   if (!r_ovld || w_out_xfer) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_page_w <= DIM_BITS'(1024);
            r_page_h <= DIM_BITS'(1024);
            r_count  <= '0;
            r_pages  <= '0;
            r_ovld   <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_mul_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_index == REG_PAGE_W) r_page_w <= i_cfg_wdata;
                else                           r_page_h <= i_cfg_wdata;
            end
            if (r_state == S_OUT && (!r_ovld || w_out_xfer)) r_ovld <= 1'b1;
            else if (w_out_xfer)                             r_ovld <= 1'b0;
            r_cmp_vld <= (r_state == S_SCAN) && (r_rd_idx < r_count);
            r_mul_vld <= r_cmp_vld && w_fit;
            priority case (r_state)
                S_IDLE: if (w_in_xfer) begin
                    r_aw      <= w_in_aw;
                    r_ah      <= w_in_ah;
                    r_pad     <= s_axis_tdata[33:26];
                    r_rd_idx  <= '0;
                    r_found   <= 1'b0;
                    if (w_in_big) r_res_st <= ST_TOOBIG;
                    else          r_res_st <= ST_PLACED;
                end
                S_SCAN: begin
                    if (r_rd_idx < r_count) begin
                        r_cmp_idx <= r_rd_idx;
                        r_rd_idx  <= r_rd_idx + 1'b1;
                    end
                    r_mul_idx  <= r_cmp_idx[IDX_BITS-1:0];
                    r_mul_area <= w_area;
                    // waste order equals area order for a fixed request
                    if (r_mul_vld && (!r_found || r_mul_area < r_best_area)) begin
                        r_found     <= 1'b1;
                        r_best      <= r_mul_idx;
                        r_best_area <= r_mul_area;
                    end
                end
                S_PICK: begin
                    r_newpage <= !r_found;
                    if (w_pick_full) begin
                        r_res_st <= ST_FULL;
                    end else if (!r_found) begin
                        // forward the new page entry; the table write lands this edge
                        r_best  <= r_count[IDX_BITS-1:0];
                        r_count <= r_count + 1'b1;
                        r_pages <= r_pages + 1'b1;
                        r_ent   <= '{page: r_pages[PG_BITS-1:0], x: '0, y: '0,
                                     w: r_page_w, h: r_page_h};
                    end
                end
                S_READ: ;
                S_SPLIT: begin
                    r_count <= r_count + 1'b1;
                end
                S_OUT: if (!r_ovld || w_out_xfer) begin
                    if (r_res_st == ST_PLACED)
                        r_odata <= {4'd0, r_ent.y + DIM_BITS'(r_pad),
                                    r_ent.x + DIM_BITS'(r_pad), r_ent.page, ST_PLACED};
                    else
                        r_odata <= {38'd0, r_res_st};
                end
                default: ;
            endcase
            if (r_state == S_READ && !r_newpage) r_ent <= w_rdata;
        end
    end

    // S_PICK addresses the chosen entry, so its data is on the read port in
    // S_READ; a new page entry is taken from the forwarded copy instead.

    property p_count_max;
        @(posedge i_clk) disable iff (!i_rst_n) r_count <= CNT_BITS'(FREE_ENTRIES);
    endproperty
    assert property (p_count_max) else $error("free count beyond table depth");

    property p_pages_max;
        @(posedge i_clk) disable iff (!i_rst_n) r_pages <= PGC_BITS'(MAX_PAGES);
    endproperty
    assert property (p_pages_max) else $error("page count beyond limit");

    property p_ready_idle;
        @(posedge i_clk) disable iff (!i_rst_n) s_axis_tready |-> (r_state == S_IDLE);
    endproperty
    assert property (p_ready_idle) else $error("ready outside idle");

    property p_count_step;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state == S_SPLIT) |=> (r_count == $past(r_count) + 1'b1);
    endproperty
    assert property (p_count_step) else $error("split did not append");

    property p_hold_out;
        @(posedge i_clk) disable iff (!i_rst_n)
            (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata);
    endproperty
    assert property (p_hold_out) else $error("result changed while stalled");
endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for guillotine_rect_packer: drives rectangle requests,
// predicts each placement with its own free-table model, checks every result.
// Depends on grp_pkg and the guillotine_rect_packer RTL.
module testbench;
    import grp_pkg::*;

    localparam int unsigned DMASK     = (1 << DIM_BITS) - 1;
    localparam int          DRAIN_CYC = FREE_ENTRIES + 40;  // scan + split + margin
    localparam int          LIMIT_CYC = 600000;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  page;
        logic [12:0] pos_x;
        logic [12:0] pos_y;
    } placement_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // rect_width[12:0] rect_height[25:13] pad[33:26]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;   // status[1:0] page_index[9:2] pos_x[22:10] pos_y[35:23]
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [12:0] i_cfg_wdata;

    guillotine_rect_packer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // Own copy of the packer state: free rectangles, fill count, pages, page size.
    int unsigned fr_page [FREE_ENTRIES];
    int unsigned fr_x    [FREE_ENTRIES];
    int unsigned fr_y    [FREE_ENTRIES];
    int unsigned fr_w    [FREE_ENTRIES];
    int unsigned fr_h    [FREE_ENTRIES];
    int unsigned fr_count;
    int unsigned pages_used;
    int unsigned cur_page_w;
    int unsigned cur_page_h;

    placement_t  placements_q[$];
    int          mismatches;
    int          sent_rects;
    int          placed_cnt;
    int          toobig_cnt;
    int          full_cnt;
    int          burst_left;
    longint      cycle_cnt = 0;

    // Free-running clock, 2 ns period.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Write one free-table entry, masked like the hardware fields.
    function automatic void set_free(int unsigned idx, int unsigned pg, int unsigned x,
                                     int unsigned y, int unsigned w, int unsigned h);
        fr_page[idx] = pg & 8'hFF;
        fr_x[idx]    = x & DMASK;
        fr_y[idx]    = y & DMASK;
        fr_w[idx]    = w & DMASK;
        fr_h[idx]    = h & DMASK;
    endfunction

    // Best-area-fit placement of one padded rectangle; updates the free table.
    function automatic placement_t place_rect(int unsigned rw, int unsigned rh,
                                              int unsigned pad);
        placement_t       res;
        int unsigned      aw, ah, best, ew, eh, ex, ey, pg;
        longint unsigned  area, waste, best_waste;
        bit               found;
        aw = rw + 2 * pad;
        ah = rh + 2 * pad;
        area = longint'(aw) * longint'(ah);
        res = '0;
        found = 0;
        best = 0;
        best_waste = 0;
        if (aw > cur_page_w || ah > cur_page_h) begin
            res.status = ST_TOOBIG;
            return res;
        end
        for (int unsigned i = 0; i < fr_count; i++) begin
            if (aw > fr_w[i] || ah > fr_h[i]) continue;
            waste = longint'(fr_w[i]) * longint'(fr_h[i]) - area;
            if (!found || waste < best_waste) begin
                found = 1;
                best_waste = waste;
                best = i;
            end
        end
        if (!found) begin
            // open a whole page; needs room for it and for the split part
            if (pages_used >= MAX_PAGES || fr_count + 2 > FREE_ENTRIES) begin
                res.status = ST_FULL;
                return res;
            end
            best = fr_count;
            set_free(best, pages_used, 0, 0, cur_page_w, cur_page_h);
            fr_count++;
            pages_used++;
        end else if (fr_count + 1 > FREE_ENTRIES) begin
            res.status = ST_FULL;
            return res;
        end
        pg = fr_page[best];
        ex = fr_x[best];
        ey = fr_y[best];
        ew = fr_w[best];
        eh = fr_h[best];
        res.status = ST_PLACED;
        res.page   = pg[7:0];
        res.pos_x  = (ex + pad) & 13'h1FFF;
        res.pos_y  = (ey + pad) & 13'h1FFF;
        // split along the axis with the smaller leftover
        if (ew - aw < eh - ah) begin
            set_free(fr_count, pg, ex, ey + ah, ew, eh - ah);
            set_free(best, pg, ex + aw, ey, ew - aw, ah);
        end else begin
            set_free(fr_count, pg, ex + aw, ey, ew - aw, eh);
            set_free(best, pg, ex, ey + ah, aw, eh - ah);
        end
        fr_count++;
        return res;
    endfunction

    // Send one request in bursts; predict on the accepting edge.
    task automatic send_rect(int unsigned rw, int unsigned rh, int unsigned pad);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tdata  <= {6'd0, pad[7:0], rh[12:0], rw[12:0]};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        placements_q.push_back(place_rect(rw & DMASK, rh & DMASK, pad & 8'hFF));
        sent_rects++;
    endtask

    // Drop valid, drain all placements and let the block settle.
    task automatic go_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (placements_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_page_size(int unsigned w, int unsigned h);
        go_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_PAGE_W;
        i_cfg_wdata <= w[12:0];
        @(posedge i_clk);
        i_cfg_index <= REG_PAGE_H;
        i_cfg_wdata <= h[12:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_page_w = w & DMASK;
        cur_page_h = h & DMASK;
    endtask

    // Default 1024 page: zero sizes, exact fit, too large, full padding, reuse.
    task automatic test_default_page();
        send_rect(0, 0, 0);
        send_rect(1024, 1024, 0);
        send_rect(1025, 0, 0);
        send_rect(0, 1025, 0);
        send_rect(0, 0, 255);
        send_rect(4096, 4096, 255);
        send_rect(1000, 10, 7);
        send_rect(10, 1000, 3);
        send_rect(5, 5, 1);
        send_rect(5, 5, 1);
        send_rect(512, 300, 0);
        go_idle();
    endtask

    // Size extremes of the page registers: one pixel, 4096, zero and all ones.
    task automatic test_page_extremes();
        write_page_size(1, 1);
        send_rect(1, 1, 0);
        send_rect(0, 0, 0);
        send_rect(2, 0, 0);
        send_rect(0, 0, 1);
        write_page_size(4096, 4096);
        send_rect(4096, 4096, 0);
        send_rect(3586, 3586, 255);
        send_rect(4096, 1, 1);
        write_page_size(0, 0);
        send_rect(0, 0, 0);
        send_rect(1, 0, 0);
        write_page_size(8191, 8191);
        send_rect(8191, 8191, 0);
        send_rect(4096, 4096, 128);
        go_idle();
    endtask

    // Random requests against a page size; mostly small enough to pack densely.
    task automatic test_random_fill(int unsigned w, int unsigned h, int count);
        int unsigned rw, rh, pad;
        write_page_size(w, h);
        repeat (count) begin
            case ($urandom_range(0, 9))
                0: begin
                    rw  = $urandom_range(0, 4096);
                    rh  = $urandom_range(0, 4096);
                    pad = $urandom_range(0, 255);
                end
                1: begin
                    rw  = $urandom_range(0, 8191);
                    rh  = $urandom_range(0, 8191);
                    pad = $urandom_range(0, 255);
                end
                default: begin
                    rw  = $urandom_range(0, w / 3 + 1);
                    rh  = $urandom_range(0, h / 3 + 1);
                    pad = $urandom_range(0, 3);
                end
            endcase
            send_rect(rw, rh, pad);
        end
        go_idle();
    endtask

    // Receiver stall pattern: long open stretches, then choppy ones.
    always @(posedge i_clk) begin
        if (cycle_cnt[8:6] < 3'd3) m_axis_tready <= 1'b1;
        else m_axis_tready <= ($urandom_range(0, 2) != 0) && (cycle_cnt[3:0] != 4'd7);
    end

    // Check each result transfer against the oldest predicted placement.
    always @(posedge i_clk) begin
        placement_t want, got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status = m_axis_tdata[1:0];
            got.page   = m_axis_tdata[9:2];
            got.pos_x  = m_axis_tdata[22:10];
            got.pos_y  = m_axis_tdata[35:23];
            if (placements_q.size() == 0) begin
                $error("unexpected result transfer: %h", m_axis_tdata);
                mismatches++;
            end else begin
                want = placements_q.pop_front();
                if (got.status != want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, got.status);
                    mismatches++;
                end
                if (got.page != want.page) begin
                    $error("page_index: expected %0d, actual %0d", want.page, got.page);
                    mismatches++;
                end
                if (got.pos_x != want.pos_x) begin
                    $error("pos_x: expected %0d, actual %0d", want.pos_x, got.pos_x);
                    mismatches++;
                end
                if (got.pos_y != want.pos_y) begin
                    $error("pos_y: expected %0d, actual %0d", want.pos_y, got.pos_y);
                    mismatches++;
                end
                case (want.status)
                    ST_PLACED: placed_cnt++;
                    ST_TOOBIG: toobig_cnt++;
                    default:   full_cnt++;
                endcase
            end
        end
    end

    // Watchdog on a hung handshake.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT_CYC) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("testbench failed");
            $finish;
        end
    end

    initial begin
        mismatches    = 0;
        sent_rects    = 0;
        placed_cnt    = 0;
        toobig_cnt    = 0;
        full_cnt      = 0;
        burst_left    = 0;
        fr_count      = 0;
        pages_used    = 0;
        cur_page_w    = 1024;
        cur_page_h    = 1024;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = REG_PAGE_W;
        i_cfg_wdata   = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_page();
        test_page_extremes();
        test_random_fill(300, 200, 150);
        test_random_fill(64, 4096, 150);
        test_random_fill(4096, 17, 150);

        $display("covered %0d requests: %0d placed, %0d too large, %0d table/page full",
                 sent_rects, placed_cnt, toobig_cnt, full_cnt);
        $display("free table entries in use at end: %0d, pages opened: %0d",
                 fr_count, pages_used);
        if (mismatches == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end
endmodule
